// ----- rtl/umpq_pkg.sv -----
// ----------------------------------------------------------------------------
// umpq_pkg: shared types and constants for the max priority queue
// Operation and status codes, field widths and default capacity.
// ----------------------------------------------------------------------------
package umpq_pkg;

   localparam int DATA_W           = 32;
   localparam int COUNT_OUT_W      = 5;
   localparam int DEFAULT_CAPACITY = 16;

   typedef logic signed [DATA_W-1:0]  value_type;
   typedef logic [COUNT_OUT_W-1:0]    count_out_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ----- rtl/umpq_if.sv -----
// ----------------------------------------------------------------------------
// umpq_if: request and response channels of the max priority queue
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface umpq_req_if;
   logic                valid;
   logic                ready;
   logic                op;
   umpq_pkg::value_type push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface umpq_rsp_if;
   logic                    valid;
   logic                    ready;
   umpq_pkg::value_type     removed_value;
   umpq_pkg::value_type     top_value;
   logic                    top_valid;
   umpq_pkg::count_out_type entry_count;
   logic [1:0]              status;

   modport source (output valid, output removed_value, output top_value,
                   output top_valid, output entry_count, output status,
                   input ready);
   modport sink   (input valid, input removed_value, input top_value,
                   input top_valid, input entry_count, input status,
                   output ready);
endinterface

// ----- rtl/unsorted_max_priority_queue.sv -----
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue: max priority queue over an unsorted store
// Entries are kept packed in slots 0..count-1 of a single-port-read memory.
// The current maximum is cached; a pop refills the freed slot with the last
// entry and rescans the store through one shared signed comparator.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  req_if   | in        | op, push_value
//  rsp_if   | out       | removed_value, top_value, top_valid, entry_count, status
//
//  Push, empty pop and full push: result valid right after the accepting edge.
//  Pop: S_MOVE_RD and S_MOVE_WR refill the freed slot, then S_SCAN rescans the
//  entries left before S_RESP; one memory read per cycle feeds the comparator.
//  Reset clears count, state and the issue and top-valid flags only; memory contents need no clearing.
//  req_if.ready is high only when idle and out of reset; a stalled response
//  holds the block.
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue #(
   parameter int CAPACITY = umpq_pkg::DEFAULT_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   umpq_req_if.sink   req_if,
   umpq_rsp_if.source rsp_if
);
   import umpq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_MOVE_RD = 5'b00010,
      S_MOVE_WR = 5'b00100,
      S_SCAN    = 5'b01000,
      S_RESP    = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic                 issue_ff, issue_in;
   logic                 top_ok_ff, top_ok_in;
   value_type            top_val_ff, top_val_in;
   logic [IDX_W-1:0]     top_idx_ff, top_idx_in;
   value_type            removed_ff, removed_in;
   status_type           status_ff, status_in;

   value_type            mem [CAPACITY];
   value_type            rd_data_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   value_type            mem_wdata;

   logic [CNT_W-1:0]     cnt_dec;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   value_type            cmp_a;
   logic                 cmp_gt;

   assign cnt_dec = count_ff - 1'b1;

   // shared signed comparator: scanned entry in S_SCAN, pushed value otherwise
   assign cmp_a  = (state_ff == S_SCAN) ? rd_data_ff : req_if.push_value;
   assign cmp_gt = (cmp_a > top_val_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_ptr_in = scan_ptr_ff;
      issue_in    = 1'b0;
      top_ok_in   = top_ok_ff;
      top_val_in  = top_val_ff;
      top_idx_in  = top_idx_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      rd_addr     = '0;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               removed_in = '0;
               status_in  = ST_OK;
               if (req_if.op == OP_POP) begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     removed_in = top_val_ff;
                     state_in   = S_MOVE_RD;
                  end
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IDX_W-1:0];
                  mem_wdata = req_if.push_value;
                  count_in  = count_ff + 1'b1;
                  if (!top_ok_ff || cmp_gt) begin
                     top_ok_in  = 1'b1;
                     top_val_in = req_if.push_value;
                     top_idx_in = count_ff[IDX_W-1:0];
                  end
                  state_in = S_RESP;
               end
            end
         end
         S_MOVE_RD: begin
            // fetch the last entry to refill the freed slot
            rd_addr  = cnt_dec[IDX_W-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            mem_we      = 1'b1;
            mem_waddr   = top_idx_ff;
            mem_wdata   = rd_data_ff;
            count_in    = cnt_dec;
            top_ok_in   = 1'b0;
            scan_ptr_in = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            // read slot ptr this cycle, compare the slot read last cycle
            if (issue_ff && (!top_ok_ff || cmp_gt)) begin
               top_ok_in  = 1'b1;
               top_val_in = rd_data_ff;
               top_idx_in = rd_idx_ff;
            end
            if (scan_ptr_ff != count_ff) begin
               rd_addr     = scan_ptr_ff[IDX_W-1:0];
               issue_in    = 1'b1;
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end else if (!issue_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         issue_ff  <= 1'b0;
         top_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         issue_ff  <= issue_in;
         top_ok_ff <= top_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      top_val_ff  <= top_val_in;
      top_idx_ff  <= top_idx_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};

   assign req_if.ready         = (state_ff == S_IDLE) && !reset;
   assign rsp_if.valid         = (state_ff == S_RESP);
   assign rsp_if.removed_value = removed_ff;
   assign rsp_if.top_value     = top_ok_ff ? top_val_ff : '0;
   assign rsp_if.top_valid     = top_ok_ff;
   assign rsp_if.entry_count   = count_ext[COUNT_OUT_W-1:0];
   assign rsp_if.status        = status_ff;

endmodule

// ----- test/tb_unsorted_max_priority_queue.sv -----
// ----------------------------------------------------------------------------
// tb_unsorted_max_priority_queue: self-checking bench for the max queue
// Drives push and pop transactions with random gaps and response stalls, and
// checks every response against a slot-level model of the unsorted store.
// ----------------------------------------------------------------------------
module tb_unsorted_max_priority_queue;
   import umpq_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_OPS  = 700;

   typedef struct {
      op_type    op;
      value_type value;
      int        gap;
      bit        drain;
   } queue_op_type;

   typedef struct {
      value_type     removed;
      value_type     top;
      logic          top_valid;
      count_out_type count;
      status_type    status;
   } queue_result_type;

   logic clock;
   logic reset;

   umpq_req_if req_if ();
   umpq_rsp_if rsp_if ();

   unsorted_max_priority_queue #(.CAPACITY(CAPACITY)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   queue_op_type     request_q[$];
   queue_result_type predicted_rsp_q[$];

   value_type slot_value[CAPACITY];
   bit        slot_used[CAPACITY];
   int        held;

   int req_count;
   int rsp_count;
   int fail_count;
   int cycles;
   int gap_left;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.op         = 1'b0;
      req_if.push_value = '0;
      rsp_if.ready      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // model: lowest free slot on push, first slot with the max on pop
   function automatic int max_slot();
      int best;
      best = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slot_used[i] && (best < 0 || slot_value[i] > slot_value[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic queue_result_type apply_queue_op(op_type op, value_type value);
      queue_result_type r;
      int               slot;
      r.removed = '0;
      r.status  = ST_OK;
      slot      = -1;
      if (op == OP_PUSH) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (!slot_used[i] && slot < 0)
               slot = i;
         end
         if (slot < 0) begin
            r.status = ST_FULL;
         end else begin
            slot_value[slot] = value;
            slot_used[slot]  = 1'b1;
            held++;
         end
      end else begin
         slot = max_slot();
         if (slot < 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.removed       = slot_value[slot];
            slot_used[slot] = 1'b0;
            held--;
         end
      end
      slot        = max_slot();
      r.top       = (slot >= 0) ? slot_value[slot] : '0;
      r.top_valid = (slot >= 0);
      r.count     = count_out_type'(held);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycles, got, want);
      fail_count++;
   endtask

   task automatic add_op(input op_type op, input value_type value, input int gap,
                         input bit drain);
      queue_op_type t;
      t.op    = op;
      t.value = value;
      t.gap   = gap;
      t.drain = drain;
      request_q.insert(request_q.size(), t);
   endtask

   function automatic value_type draw_value(int mode);
      value_type v;
      case (mode)
         0: v = value_type'($urandom);
         1: v = value_type'($signed($urandom_range(0, 6)) - 3);
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 32'sh0000_0000;
               default: v = 32'shFFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   // driver
   always @(posedge clock) begin : driver
      bit load;
      load = 1'b0;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     <= 0;
         req_count    <= 0;
      end else if (req_if.valid && req_if.ready) begin
         predicted_rsp_q.insert(predicted_rsp_q.size(),
                                apply_queue_op(request_q[0].op, request_q[0].value));
         req_count <= req_count + 1;
         void'(request_q.pop_front());
         if (request_q.size() > 0 && request_q[0].gap == 0 && !request_q[0].drain)
            load = 1'b1;
         else
            gap_left <= (request_q.size() > 0) ? request_q[0].gap : 0;
         if (!load)
            req_if.valid <= 1'b0;
      end else if (!req_if.valid) begin
         if (gap_left > 0)
            gap_left <= gap_left - 1;
         else if (request_q.size() > 0 && (!request_q[0].drain || req_count == rsp_count))
            load = 1'b1;
      end
      if (load) begin
         req_if.valid      <= 1'b1;
         req_if.op         <= request_q[0].op;
         req_if.push_value <= request_q[0].value;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      queue_result_type want;
      int               s;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
         rsp_count    <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         rsp_count <= rsp_count + 1;
         if (predicted_rsp_q.size() == 0) begin
            report_mismatch("response count", rsp_count + 1, rsp_count);
         end else begin
            want = predicted_rsp_q.pop_front();
            if (rsp_if.removed_value !== want.removed)
               report_mismatch("removed_value", $signed(rsp_if.removed_value), want.removed);
            if (rsp_if.top_value !== want.top)
               report_mismatch("top_value", $signed(rsp_if.top_value), want.top);
            if (rsp_if.top_valid !== want.top_valid)
               report_mismatch("top_valid", rsp_if.top_valid, want.top_valid);
            if (rsp_if.entry_count !== want.count)
               report_mismatch("entry_count", rsp_if.entry_count, want.count);
            if (rsp_if.status !== want.status)
               report_mismatch("status", rsp_if.status, want.status);
         end
         // every 64 responses, a stretch of 16 with no stall
         s = ((rsp_count % 64) < 16) ? 0 : $urandom_range(0, 5);
         rsp_if.ready <= (s == 0);
         stall_left   <= s;
      end else if (!rsp_if.ready) begin
         if (stall_left <= 1)
            rsp_if.ready <= 1'b1;
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int seg_len;
      int push_pct;
      int vmode;
      int gap;
      bit no_idle;
      bit drain;
      int added;
      cycles     = 0;
      fail_count = 0;
      held       = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         slot_used[i]  = 1'b0;
         slot_value[i] = '0;
      end

      // directed: pop on empty, extremes, equal maxima, fill to full, push on full, then seven pops
      add_op(OP_POP,  32'sh1234_5678, $urandom_range(0, 5), 1'b0);
      add_op(OP_PUSH, 32'sh8000_0000, $urandom_range(0, 5), 1'b0);
      add_op(OP_PUSH, 32'sh7FFF_FFFF, $urandom_range(0, 5), 1'b0);
      add_op(OP_PUSH, 32'shFFFF_FFFF, $urandom_range(0, 5), 1'b0);
      add_op(OP_PUSH, 32'sh0000_0000, 0, 1'b0);
      add_op(OP_PUSH, 32'sh7FFF_FFFF, 0, 1'b0);
      add_op(OP_PUSH, 32'sh0000_0005, 0, 1'b0);
      add_op(OP_PUSH, 32'sh0000_0005, 0, 1'b0);
      for (int i = 0; i < 9; i++)
         add_op(OP_PUSH, value_type'($urandom), $urandom_range(0, 5), 1'b0);
      add_op(OP_PUSH, 32'sh5555_AAAA, $urandom_range(0, 5), 1'b0);
      for (int i = 0; i < 7; i++)
         add_op(OP_POP, value_type'($urandom), $urandom_range(0, 5), 1'b0);

      // random segments with their own push bias, value mix and idling
      added = 0;
      while (added < RANDOM_OPS) begin
         seg_len = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: push_pct = 80;
            1: push_pct = 50;
            default: push_pct = 20;
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: vmode = 0;
            10, 11, 12, 13, 14, 15, 16: vmode = 1;
            default: vmode = 2;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < seg_len && added < RANDOM_OPS; i++) begin
            gap   = no_idle ? 0 : $urandom_range(0, 5);
            drain = (added == 0) || (i == 0 && $urandom_range(0, 9) == 0);
            if ($urandom_range(1, 100) <= push_pct)
               add_op(OP_PUSH, draw_value(vmode), gap, drain);
            else
               add_op(OP_POP, value_type'($urandom), gap, drain);
            added++;
         end
      end

      while (request_q.size() != 0 || req_count != rsp_count)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (predicted_rsp_q.size() != 0)
         report_mismatch("response count", rsp_count, rsp_count + predicted_rsp_q.size());
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
